[hw/rtl/c2s_pkg.sv]
// Types, constants and datapath helpers shared by the Cartesian-to-spherical converter.
`timescale 1ns / 1ps

package c2s_pkg;

  localparam int COORD_BITS    = 32;
  localparam int CORDIC_STAGES = 32;
  localparam int ANGLE_W       = 32;
  localparam int RAD_W         = 32;
  localparam int DATA_W        = 64;
  localparam int HALF_W        = DATA_W / 2;
  localparam int GUARD_BITS    = 60 - COORD_BITS;
  localparam int ATAN_LEN      = 48;
  localparam int ATAN_IDX_W    = $clog2(ATAN_LEN);

  // round(2^32 / K), K being the gain of an unbounded CORDIC chain
  localparam logic [HALF_W-1:0]  INV_GAIN_Q32 = 32'd2608131496;
  localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;

  // round(atan(2^-i) * 2^31 / pi)
  localparam logic [ANGLE_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0,         32'd0,         32'd0,        32'd0,
    32'd0,         32'd0,         32'd0,         32'd0,        32'd0,
    32'd0,         32'd0,         32'd0,         32'd0,        32'd0,
    32'd0,         32'd0,         32'd0
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic signed [COORD_BITS-1:0] z_coord;
  } c2s_in_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] azimuth;
    logic signed [ANGLE_W-1:0] elevation;
    logic        [RAD_W-1:0]   radius;
  } c2s_out_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic        [ANGLE_W-1:0] ang;
  } cordic_t;

  typedef struct packed {
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
  } gain_prod_t;

  // Sideband riding along the azimuth pass
  typedef struct packed {
    logic                         bypass;
    logic                         x_neg;
    logic        [COORD_BITS-1:0] abs_x;
    logic signed [COORD_BITS-1:0] z;
  } az_side_t;

  // Sideband riding along the elevation pass
  typedef struct packed {
    logic [ANGLE_W-1:0] azimuth;
    logic               bypass;
    logic [ANGLE_W-1:0] el_fix;
    logic [RAD_W-1:0]   rad_fix;
  } el_side_t;

  // One vectoring micro-rotation; drive y toward zero.
  function automatic cordic_t cordic_step(cordic_t c, logic [ATAN_IDX_W-1:0] idx);
    cordic_t n;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    dx = c.y >>> idx;
    dy = c.x >>> idx;
    if (!c.y[DATA_W-1]) begin
      n.x   = c.x + dx;
      n.y   = c.y - dy;
      n.ang = c.ang + ATAN_TAB[idx];
    end else begin
      n.x   = c.x - dx;
      n.y   = c.y + dy;
      n.ang = c.ang - ATAN_TAB[idx];
    end
    return n;
  endfunction

  // Two 32x32 partial products of the 1/K scaling; negative clamps to zero.
  function automatic gain_prod_t gain_mul(logic signed [DATA_W-1:0] v);
    gain_prod_t p;
    logic [DATA_W-1:0] u;
    u    = v[DATA_W-1] ? '0 : v;
    p.hi = DATA_W'(u[DATA_W-1:HALF_W]) * DATA_W'(INV_GAIN_Q32);
    p.lo = DATA_W'(u[HALF_W-1:0]) * DATA_W'(INV_GAIN_Q32);
    return p;
  endfunction

  function automatic logic signed [DATA_W-1:0] gain_sum(gain_prod_t p);
    return p.hi + (p.lo >> HALF_W);
  endfunction

  // Drop guard bits with round-half-up, saturate to the radius width.
  function automatic logic [RAD_W-1:0] round_sat(logic signed [DATA_W-1:0] r);
    logic [DATA_W-1:0] t;
    logic [RAD_W-1:0]  res;
    t = r[DATA_W-1] ? '0 : r;
    t = (t + (DATA_W'(1) << (GUARD_BITS - 1))) >> GUARD_BITS;
    if (t[DATA_W-1:RAD_W] != '0) begin
      res = '1;
    end else begin
      res = t[RAD_W-1:0];
    end
    return res;
  endfunction

endpackage

[hw/rtl/cartesian_to_spherical.sv]
// Cartesian-to-spherical converter: two pipelined CORDIC vectoring passes.
`timescale 1ns / 1ps

// Converts a signed point (x, y, z) to azimuth atan2(y, x), elevation
// atan2(z, hypot(x, y)) and radius |(x, y, z)|. Angles are binary angles in
// which 2^31 is pi; the radius is rounded to the nearest integer and
// saturates at 2^32-1. The datapath is a fully pipelined chain: one input
// stage, CORDIC_STAGES rotation stages for the azimuth, two stages of 1/K
// gain scaling (two 32x32 multiplies, then the add), one setup stage for the
// elevation, CORDIC_STAGES rotation stages for the elevation, two more gain
// stages, one rounding stage and the output register. A new beat is
// accepted every cycle while the skid register is empty. The output
// register is backed by a one-beat skid register; in_stall_o rises only
// when both are full, so the input side stays open while a finished result
// waits to be taken. Points with y = 0, z = 0 or x = y = 0 take exact
// bypass values instead of the CORDIC results.
module cartesian_to_spherical (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  c2s_pkg::c2s_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output c2s_pkg::c2s_out_t  out_data_o
);

  localparam int N  = c2s_pkg::CORDIC_STAGES;
  localparam int CB = c2s_pkg::COORD_BITS;
  localparam int DW = c2s_pkg::DATA_W;

  // Whole chain moves together; it freezes only while the skid register holds a beat.
  logic adv;
  logic accept;

  // ---------------- input stage and azimuth pass ----------------
  logic                vp_q [0:N];
  c2s_pkg::cordic_t    c1_q [0:N];
  c2s_pkg::az_side_t   s1_q [0:N];

  c2s_pkg::cordic_t    c1_d;
  c2s_pkg::az_side_t   s1_d;
  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;
  logic                 x_neg;

  always_comb begin
    xs    = {{(DW-CB){in_data_i.x_coord[CB-1]}}, in_data_i.x_coord};
    ys    = {{(DW-CB){in_data_i.y_coord[CB-1]}}, in_data_i.y_coord};
    x_neg = in_data_i.x_coord[CB-1];
    // Left half plane: rotate by pi so the vector starts with x >= 0
    if (x_neg) begin
      xs = -xs;
      ys = -ys;
    end
    c1_d.x       = xs <<< c2s_pkg::GUARD_BITS;
    c1_d.y       = ys <<< c2s_pkg::GUARD_BITS;
    c1_d.ang     = x_neg ? c2s_pkg::HALF_TURN : '0;
    // On the x axis the horizontal length is |x| exactly
    s1_d.bypass  = (in_data_i.y_coord == '0);
    s1_d.x_neg   = x_neg;
    s1_d.abs_x   = x_neg ? CB'(-in_data_i.x_coord) : CB'(in_data_i.x_coord);
    s1_d.z       = in_data_i.z_coord;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q[0] <= 1'b0;
    end else if (adv) begin
      vp_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q[0] <= c1_d;
      s1_q[0] <= s1_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_az_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vp_q[i+1] <= 1'b0;
      end else if (adv) begin
        vp_q[i+1] <= vp_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        c1_q[i+1] <= c2s_pkg::cordic_step(c1_q[i], c2s_pkg::ATAN_IDX_W'(i));
        s1_q[i+1] <= s1_q[i];
      end
    end
  end

  // ---------------- azimuth-pass gain scaling ----------------
  logic                        vg1_q, vg2_q;
  c2s_pkg::gain_prod_t         gp1_q;
  c2s_pkg::az_side_t           sg1_q, sg2_q;
  logic [c2s_pkg::ANGLE_W-1:0] azg1_q, azg2_q;
  logic signed [DW-1:0]        h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg1_q <= 1'b0;
      vg2_q <= 1'b0;
    end else if (adv) begin
      vg1_q <= vp_q[N];
      vg2_q <= vg1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gp1_q  <= c2s_pkg::gain_mul(c1_q[N].x);
      sg1_q  <= s1_q[N];
      // Exact azimuth on the x axis: pi when x < 0, else zero
      azg1_q <= s1_q[N].bypass ? (s1_q[N].x_neg ? c2s_pkg::HALF_TURN : '0)
                               : c1_q[N].ang;
      h_q    <= sg1_q.bypass ? (DW'(sg1_q.abs_x) <<< c2s_pkg::GUARD_BITS)
                             : c2s_pkg::gain_sum(gp1_q);
      sg2_q  <= sg1_q;
      azg2_q <= azg1_q;
    end
  end

  // ---------------- elevation setup and pass ----------------
  logic                v2_q [0:N];
  c2s_pkg::cordic_t    c2_q [0:N];
  c2s_pkg::el_side_t   s2_q [0:N];

  c2s_pkg::cordic_t    c2_d;
  c2s_pkg::el_side_t   s2_d;
  logic signed [DW-1:0] zs;
  logic [CB-1:0]        abs_z;

  always_comb begin
    zs          = {{(DW-CB){sg2_q.z[CB-1]}}, sg2_q.z};
    abs_z       = sg2_q.z[CB-1] ? CB'(-sg2_q.z) : CB'(sg2_q.z);
    c2_d.x      = h_q;
    c2_d.y      = zs <<< c2s_pkg::GUARD_BITS;
    c2_d.ang    = '0;
    s2_d.azimuth = azg2_q;
    s2_d.bypass  = 1'b0;
    s2_d.el_fix  = '0;
    s2_d.rad_fix = '0;
    if (sg2_q.z == '0) begin
      // In the horizontal plane: radius is the horizontal length
      s2_d.bypass  = 1'b1;
      s2_d.rad_fix = c2s_pkg::round_sat(h_q);
    end else if (h_q == '0) begin
      // On the z axis: straight up or down
      s2_d.bypass  = 1'b1;
      s2_d.el_fix  = sg2_q.z[CB-1] ? -c2s_pkg::QUARTER_TURN : c2s_pkg::QUARTER_TURN;
      s2_d.rad_fix = c2s_pkg::RAD_W'(abs_z);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q[0] <= 1'b0;
    end else if (adv) begin
      v2_q[0] <= vg2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_q[0] <= c2_d;
      s2_q[0] <= s2_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_el_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v2_q[i+1] <= 1'b0;
      end else if (adv) begin
        v2_q[i+1] <= v2_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        c2_q[i+1] <= c2s_pkg::cordic_step(c2_q[i], c2s_pkg::ATAN_IDX_W'(i));
        s2_q[i+1] <= s2_q[i];
      end
    end
  end

  // ---------------- radius gain scaling and rounding ----------------
  logic                vh1_q, vh2_q, vf_q;
  c2s_pkg::gain_prod_t gp2_q;
  c2s_pkg::el_side_t   sh1_q, sh2_q;
  logic signed [DW-1:0] r_q;
  c2s_pkg::c2s_out_t   f_q;
  c2s_pkg::el_side_t   sh1_d;

  always_comb begin
    sh1_d = s2_q[N];
    // Fold the CORDIC elevation into the sideband unless a bypass value stands
    if (!s2_q[N].bypass) begin
      sh1_d.el_fix = c2_q[N].ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh1_q <= 1'b0;
      vh2_q <= 1'b0;
      vf_q  <= 1'b0;
    end else if (adv) begin
      vh1_q <= v2_q[N];
      vh2_q <= vh1_q;
      vf_q  <= vh2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gp2_q         <= c2s_pkg::gain_mul(c2_q[N].x);
      sh1_q         <= sh1_d;
      r_q           <= c2s_pkg::gain_sum(gp2_q);
      sh2_q         <= sh1_q;
      f_q.azimuth   <= sh2_q.azimuth;
      f_q.elevation <= sh2_q.el_fix;
      f_q.radius    <= sh2_q.bypass ? sh2_q.rad_fix : c2s_pkg::round_sat(r_q);
    end
  end

  // ---------------- output register and skid ----------------
  logic              out_valid_q, out_valid_d;
  logic              skid_q, skid_d;
  c2s_pkg::c2s_out_t out_q, skid_data_q;
  logic              load_out, load_skid;
  logic              out_take, f_leave;

  assign adv      = !skid_q;
  assign accept   = in_valid_i && !skid_q;
  assign out_take = out_valid_q && !out_stall_i;
  assign f_leave  = vf_q && adv;

  always_comb begin
    out_valid_d = out_valid_q;
    skid_d      = skid_q;
    load_out    = 1'b0;
    load_skid   = 1'b0;
    if (skid_q) begin
      // Drain the skid beat into the output as soon as the output is taken
      if (out_take) begin
        load_out = 1'b1;
        skid_d   = 1'b0;
      end
    end else if (f_leave) begin
      if (!out_valid_q || out_take) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid = 1'b1;
        skid_d    = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_q      <= skid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_q ? skid_data_q : f_q;
    end
    if (load_skid) begin
      skid_data_q <= f_q;
    end
  end

  assign in_stall_o  = skid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  a_skid_behind_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |-> out_valid_q)
    else $error("skid register holds a beat while the output register is empty");

  a_skid_fills_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_q) |-> $past(out_valid_q && out_stall_i && vf_q))
    else $error("skid register filled without a stalled output beat");

  a_frozen_chain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |=> ($stable(vf_q) && $stable(vp_q[0])))
    else $error("pipeline moved while the skid register was full");

  a_accept_only_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && adv) |=> vp_q[0])
    else $error("accepted beat did not enter the input stage");

endmodule

[dv/tb_cartesian_to_spherical.sv]
// Self-checking testbench for the Cartesian-to-spherical converter.
`timescale 1ns / 1ps

// Feed the converter with points, predict each beat's azimuth, elevation and
// radius with an independent bit-exact model of the two CORDIC vectoring
// passes, and compare every output beat in order. Traffic runs in phases:
// no idling, sender gaps, receiver stalls, and light gaps on both sides. One
// long receiver hold-off fills the pipeline and forces input backpressure.
module tb_cartesian_to_spherical;

  localparam int          COORD_W     = 32;
  localparam int          ROT_STAGES  = 32;
  localparam int          FRAC_BITS   = 60 - COORD_W;
  localparam longint      COORD_SCALE = longint'(1) <<< FRAC_BITS;
  localparam logic [63:0] INV_GAIN    = 64'd2608131496;
  localparam logic [31:0] PI_ANGLE    = 32'h8000_0000;
  localparam logic [31:0] HALF_PI     = 32'h4000_0000;
  localparam int          CMAX        = 32'h7fff_ffff;
  localparam int          CMIN        = int'(32'h8000_0000);
  localparam int          PER_PHASE   = 363;
  localparam int          HOLD_CYCLES = 200;
  localparam int          DRAIN       = 150;
  localparam int          NDIRECTED   = 25;

  // atan(2^-i) in binary-angle units, pi = 2^31
  localparam logic [31:0] ARCTAN [48] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0,         32'd0,         32'd0,        32'd0,
    32'd0,         32'd0,         32'd0,         32'd0,        32'd0,
    32'd0,         32'd0,         32'd0,         32'd0,        32'd0,
    32'd0,         32'd0,         32'd0
  };

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH_GAPS
  } traffic_t;

  typedef struct {
    c2s_pkg::c2s_in_t pt;
    traffic_t         traffic;
    bit               hold;
  } point_req_t;

  typedef struct {
    c2s_pkg::c2s_in_t  pt;
    c2s_pkg::c2s_out_t res;
  } sphere_beat_t;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall_o;
  c2s_pkg::c2s_in_t  in_data   = '0;
  logic              out_valid_o;
  logic              out_stall = 1'b0;
  c2s_pkg::c2s_out_t out_data_o;

  point_req_t   pending_pts [$];
  sphere_beat_t sphere_q [$];
  point_req_t   next_pt;
  sphere_beat_t want;
  traffic_t     cur_traffic  = PH_STEADY;
  bit           hold_armed   = 1'b0;
  bit           hold_done    = 1'b0;
  int           hold_left    = 0;
  bit           in_taken     = 1'b0;
  int           mismatch_cnt = 0;

  cartesian_to_spherical dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Rotate (vx, vy) onto the positive x axis; accumulate the angle turned.
  // Shifts are arithmetic, so they floor toward minus infinity.
  function automatic void rotate_to_axis(inout longint vx, inout longint vy,
                                         inout logic [31:0] ang);
    longint sx;
    longint sy;
    for (int i = 0; i < ROT_STAGES; i++) begin
      sx = vy >>> i;
      sy = vx >>> i;
      if (vy >= 0) begin
        vx  = vx + sx;
        vy  = vy - sy;
        ang = ang + ARCTAN[i];
      end else begin
        vx  = vx - sx;
        vy  = vy + sy;
        ang = ang - ARCTAN[i];
      end
    end
  endfunction

  // Scale a magnitude by 1/K in Q32, flooring each partial product.
  function automatic longint apply_inv_gain(longint v);
    logic [63:0] u;
    logic [63:0] hi;
    logic [63:0] lo;
    u  = (v < 0) ? 64'd0 : 64'(v);
    hi = (u >> 32) * INV_GAIN;
    lo = ((u & 64'hffff_ffff) * INV_GAIN) >> 32;
    return longint'(hi + lo);
  endfunction

  function automatic c2s_pkg::c2s_out_t spherical_of(c2s_pkg::c2s_in_t p);
    c2s_pkg::c2s_out_t o;
    longint            px;
    longint            py;
    longint            pz;
    longint            horiz;
    longint            len;
    longint            cx;
    longint            cy;
    logic [31:0]       az;
    logic [31:0]       el;
    logic [63:0]       rnd;
    px = longint'($signed(p.x_coord));
    py = longint'($signed(p.y_coord));
    pz = longint'($signed(p.z_coord));

    // On the x axis the azimuth and the horizontal length are exact.
    if (py == 0) begin
      az    = (px < 0) ? PI_ANGLE : 32'd0;
      horiz = ((px < 0) ? -px : px) * COORD_SCALE;
    end else begin
      az = 32'd0;
      // Fold the left half plane over: negate the vector, start at pi.
      if (px < 0) begin
        px = -px;
        py = -py;
        az = PI_ANGLE;
      end
      cx = px * COORD_SCALE;
      cy = py * COORD_SCALE;
      rotate_to_axis(cx, cy, az);
      horiz = apply_inv_gain(cx);
    end

    if (pz == 0) begin
      el  = 32'd0;
      len = horiz;
    end else if (horiz == 0) begin
      // Straight up or down the z axis.
      el  = (pz > 0) ? HALF_PI : (32'd0 - HALF_PI);
      len = ((pz < 0) ? -pz : pz) * COORD_SCALE;
    end else begin
      cx = horiz;
      cy = pz * COORD_SCALE;
      el = 32'd0;
      rotate_to_axis(cx, cy, el);
      len = apply_inv_gain(cx);
    end

    // Round half up out of the guard bits, saturate to 32 bits.
    rnd = ((len < 0) ? 64'd0 : 64'(len)) + (64'd1 << (FRAC_BITS - 1));
    rnd = rnd >> FRAC_BITS;
    o.azimuth   = az;
    o.elevation = el;
    o.radius    = (rnd > 64'hffff_ffff) ? 32'hffff_ffff : rnd[31:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Pick a coordinate: mostly full range, with small, zero and corner values.
  function automatic logic [31:0] random_coord();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      return $urandom();
    end else if (r < 75) begin
      return $urandom_range(2000) - 1000;
    end else if (r < 87) begin
      return '0;
    end
    case ($urandom_range(3))
      0:       return CMIN;
      1:       return CMAX;
      2:       return 32'hffff_ffff;
      default: return 32'd1;
    endcase
  endfunction

  function automatic bit roll_idle(traffic_t t, bit recv_side);
    int pct;
    case (t)
      PH_SEND_GAPS:   pct = recv_side ? 0 : 78;
      PH_RECV_STALLS: pct = recv_side ? 78 : 0;
      PH_BOTH_GAPS:   pct = 17;
      default:        pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  task automatic queue_point(int x, int y, int z, traffic_t t, bit hold);
    point_req_t r;
    r.pt.x_coord = x;
    r.pt.y_coord = y;
    r.pt.z_coord = z;
    r.traffic    = t;
    r.hold       = hold;
    pending_pts.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: advance to the next point once the current beat is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (pending_pts.size() != 0 && !roll_idle(pending_pts[0].traffic, 1'b0)) begin
        next_pt = pending_pts.pop_front();
        in_data     <= next_pt.pt;
        in_valid    <= 1'b1;
        cur_traffic <= next_pt.traffic;
        if (next_pt.hold) begin
          hold_armed <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per phase, plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_armed && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= roll_idle(cur_traffic, 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check output beats first, then record accepted input beats
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (sphere_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: unexpected beat az=%0d el=%0d r=%0d", $realtime,
                     out_data_o.azimuth, out_data_o.elevation, out_data_o.radius);
          end
        end else begin
          want = sphere_q.pop_front();
          if (out_data_o.azimuth !== want.res.azimuth ||
              out_data_o.elevation !== want.res.elevation ||
              out_data_o.radius !== want.res.radius) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: mismatch for (%0d, %0d, %0d)", $realtime,
                       want.pt.x_coord, want.pt.y_coord, want.pt.z_coord);
              $display("  azimuth   exp %0d got %0d", want.res.azimuth,
                       out_data_o.azimuth);
              $display("  elevation exp %0d got %0d", want.res.elevation,
                       out_data_o.elevation);
              $display("  radius    exp %0d got %0d", want.res.radius,
                       out_data_o.radius);
            end
          end
        end
      end
      if (in_valid && !in_stall_o) begin
        want.pt  = in_data;
        want.res = spherical_of(in_data);
        sphere_q.push_back(want);
        in_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int       dir_pts [NDIRECTED][3];
    traffic_t ph;
    int       x;
    int       y;
    dir_pts = '{
      '{0, 0, 0},          '{CMAX, 0, 0},        '{CMIN, 0, 0},
      '{-1, 0, 0},         '{0, CMAX, 0},        '{0, CMIN, 0},
      '{0, 0, CMAX},       '{0, 0, CMIN},        '{0, 0, 1},
      '{0, 0, -1},         '{CMIN, CMIN, CMIN},  '{CMAX, CMAX, CMAX},
      '{CMIN, CMAX, CMAX}, '{CMAX, CMIN, CMIN},  '{-7, 3, 0},
      '{-7, -3, 5},        '{3, 4, 0},           '{3, 4, 12},
      '{1, 1, 1},          '{-1, -1, -1},        '{0, 1, 0},
      '{0, -1, -1},        '{-5, 0, 7},          '{CMIN, 0, CMIN},
      '{1, 0, CMAX}
    };

    // Directed corners: axes, origin, left half plane, full-scale points.
    for (int i = 0; i < NDIRECTED; i++) begin
      queue_point(dir_pts[i][0], dir_pts[i][1], dir_pts[i][2], PH_STEADY, 1'b0);
    end

    // Random points, one traffic phase after another. Arm the long hold-off
    // at the head of the steady phase so the sender keeps pushing into it.
    for (int p = 0; p < 4; p++) begin
      ph = traffic_t'(p);
      for (int i = 0; i < PER_PHASE; i++) begin
        if ($urandom_range(19) == 0) begin
          x = 0;
          y = 0;
        end else begin
          x = random_coord();
          y = random_coord();
        end
        queue_point(x, y, random_coord(), ph, (ph == PH_STEADY) && (i == 0));
      end
    end

    // Hold reset, then release it away from the active edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every point to go in and every beat to come back.
    while (pending_pts.size() != 0 || in_valid || sphere_q.size() != 0) begin
      @(posedge clk_i);
    end
    // Let the pipeline run dry; any stray beat is flagged by the monitor.
    repeat (DRAIN) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("PASS cartesian_to_spherical");
    end else begin
      $display("FAIL cartesian_to_spherical");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("FAIL cartesian_to_spherical");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/c2s_pkg.sv
hw/rtl/cartesian_to_spherical.sv
dv/tb_cartesian_to_spherical.sv
